### rtl/sorted_unique_id_list_core_assert.svh
// Assertion macros used by the checker of the sorted id list.
`ifndef SORTED_UNIQUE_ID_LIST_CORE_ASSERT_SVH
`define SORTED_UNIQUE_ID_LIST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SUIDL_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SUIDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/suidl_pkg.sv
package suidl_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 3'd0,
        ST_DUP   = 3'd1,
        ST_ZERO  = 3'd2,
        ST_FULL  = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_SWEEP = 1'b1
    } fsm_t;

    // Control part of the request token that walks down the cell chain.
    typedef struct packed {
        logic valid;
        logic is_read;
        logic dup;
    } tok_ctrl_t;

endpackage

### rtl/suidl_cell.sv
module suidl_cell #(
    parameter int IDX      = 0,
    parameter int ID_WIDTH = 12,
    parameter int COUNT_W  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COUNT_W-1:0]    count,
    input  suidl_pkg::tok_ctrl_t  in_ctrl,
    input  logic [ID_WIDTH-1:0]   in_id,
    input  logic [COUNT_W-1:0]    in_idx,
    output suidl_pkg::tok_ctrl_t  out_ctrl,
    output logic [ID_WIDTH-1:0]   out_id,
    output logic [COUNT_W-1:0]    out_idx
);
    import suidl_pkg::*;

    localparam logic [COUNT_W-1:0] POS = COUNT_W'(IDX);

    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    tok_ctrl_t           ctrl_reg;
    tok_ctrl_t           ctrl_next;
    logic [ID_WIDTH-1:0] tok_id_reg;
    logic [ID_WIDTH-1:0] tok_id_next;
    logic [COUNT_W-1:0]  tok_idx_reg;

    // A live insert keeps the smaller of its own entry and the passing id and
    // hands the larger one on; the first empty cell takes what arrives.
    always_comb
    begin
        id_next     = id_reg;
        ctrl_next   = in_ctrl;
        tok_id_next = in_id;
        if (in_ctrl.valid)
        begin
            if (in_ctrl.is_read)
            begin
                if (in_idx == POS)
                begin
                    tok_id_next = id_reg;
                end
            end
            else if (!in_ctrl.dup)
            begin
                if (POS == count)
                begin
                    id_next = in_id;
                end
                else if (POS < count)
                begin
                    if (id_reg == in_id)
                    begin
                        ctrl_next.dup = 1'b1;
                    end
                    else if (id_reg > in_id)
                    begin
                        id_next     = in_id;
                        tok_id_next = id_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        tok_id_reg  <= tok_id_next;
        tok_idx_reg <= in_idx;
    end

    assign out_ctrl = ctrl_reg;
    assign out_id   = tok_id_reg;
    assign out_idx  = tok_idx_reg;

endmodule

### rtl/sorted_unique_id_list_core.sv
// Sorted unique id list. The block holds up to CAPACITY nonzero ids of
// ID_WIDTH bits in ascending order, one id per cell of a chain of cells.
// Each request on the slave side carries a kind in tuser: insert places
// core_id at its sorted place, read returns the entry at entry_index, and
// clear empties the list. Every request yields exactly one response on the
// master side with a status, the entry count after the request, and the
// read id (zero unless a read succeeded). Requests that can be answered
// from the count alone (clear, the unused kind, an id of zero, an insert
// into a full list, a read at or beyond the count) are answered in the
// cycle after acceptance, and another such request may follow in every
// cycle while the response is drained. An insert or an in-range read
// sends a token down the whole chain, one cell per cycle, from the launch
// register through every cell, so the length of the cell chain sets when
// its response reaches the output register and the next request is taken.
// While a token is in flight no new request is accepted. The response waits
// in an output register; a new request is taken only while that register is
// empty or is being drained in the same cycle.
// Stored entries need no clearing after reset: only cells below the count
// are ever looked at.
module sorted_unique_id_list_core #(
    parameter int CAPACITY = 256,
    parameter int ID_WIDTH = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Request channel.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: core_id, then entry_index (8 bits), zero padded to bytes.
    input  logic [((ID_WIDTH + suidl_pkg::INDEX_W + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: kind.
    input  logic [suidl_pkg::KIND_W-1:0]           s_tuser,
    // Response channel.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: status (3 bits), entry_count, read_id, zero padded to bytes.
    output logic [((suidl_pkg::STATUS_W + $clog2(CAPACITY + 1) + ID_WIDTH + 7) / 8) * 8 - 1:0]
                                                   m_tdata
);
    import suidl_pkg::*;

    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;
    localparam int OUT_DATA_W = ((STATUS_W + COUNT_W + ID_WIDTH + 7) / 8) * 8;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // Request fields.
    logic [ID_WIDTH-1:0] core_id;
    logic [INDEX_W-1:0]  entry_index;
    kind_t               kind;
    logic                accept;

    assign core_id     = s_tdata[ID_WIDTH-1:0];
    assign entry_index = s_tdata[ID_WIDTH +: INDEX_W];
    assign kind        = kind_t'(s_tuser);
    assign accept      = s_tvalid && s_tready;

    // Control and output registers.
    fsm_t                state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [ID_WIDTH-1:0] out_id_reg, out_id_next;

    // Token launch register feeding the head of the chain.
    tok_ctrl_t           launch_ctrl_reg, launch_ctrl_next;
    logic [ID_WIDTH-1:0] launch_id_reg, launch_id_next;
    logic [COUNT_W-1:0]  launch_idx_reg, launch_idx_next;

    // Chain links: link 0 is the launch register, link CAPACITY the tail.
    tok_ctrl_t           link_ctrl [CAPACITY+1];
    logic [ID_WIDTH-1:0] link_id   [CAPACITY+1];
    logic [COUNT_W-1:0]  link_idx  [CAPACITY+1];
    tok_ctrl_t           tail_ctrl;
    logic [ID_WIDTH-1:0] tail_id;

    assign link_ctrl[0] = launch_ctrl_reg;
    assign link_id[0]   = launch_id_reg;
    assign link_idx[0]  = launch_idx_reg;
    assign tail_ctrl    = link_ctrl[CAPACITY];
    assign tail_id      = link_id[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        suidl_cell #(
            .IDX      (i),
            .ID_WIDTH (ID_WIDTH),
            .COUNT_W  (COUNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .count    (count_reg),
            .in_ctrl  (link_ctrl[i]),
            .in_id    (link_id[i]),
            .in_idx   (link_idx[i]),
            .out_ctrl (link_ctrl[i+1]),
            .out_id   (link_id[i+1]),
            .out_idx  (link_idx[i+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (launch_ctrl_next.valid)
                begin
                    state_next = FSM_SWEEP;
                end
            end
            FSM_SWEEP:
            begin
                if (tail_ctrl.valid)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Handshake outputs. A request is taken only when the output register
    // is free or being drained in the same cycle.
    always_comb
    begin
        s_tready = (state_reg == FSM_IDLE) && (!out_valid_reg || m_tready);
        m_tvalid = out_valid_reg;
        m_tdata  = OUT_DATA_W'({out_id_reg, out_count_reg, out_status_reg});
    end

    // Request decode, token launch and response capture.
    always_comb
    begin
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        out_id_next      = out_id_reg;
        launch_ctrl_next = '0;
        launch_id_next   = core_id;
        launch_idx_next  = COUNT_W'(entry_index);

        if (accept)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_DONE;
            out_count_next  = count_reg;
            out_id_next     = '0;
            case (kind)
                KIND_INSERT:
                begin
                    if (core_id == '0)
                    begin
                        out_status_next = ST_ZERO;
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        out_valid_next         = 1'b0;
                        launch_ctrl_next.valid = 1'b1;
                    end
                end
                KIND_READ:
                begin
                    if (CMP_W'(entry_index) < CMP_W'(count_reg))
                    begin
                        out_valid_next           = 1'b0;
                        launch_ctrl_next.valid   = 1'b1;
                        launch_ctrl_next.is_read = 1'b1;
                        launch_id_next           = '0;
                    end
                    else
                    begin
                        out_status_next = ST_RANGE;
                    end
                end
                KIND_CLEAR:
                begin
                    count_next     = '0;
                    out_count_next = '0;
                end
                default:
                begin
                    out_status_next = ST_DONE;
                end
            endcase
        end

        // The token leaving the last cell carries the outcome.
        if (tail_ctrl.valid)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_DONE;
            out_count_next  = count_reg;
            out_id_next     = '0;
            if (tail_ctrl.is_read)
            begin
                out_id_next = tail_id;
            end
            else if (tail_ctrl.dup)
            begin
                out_status_next = ST_DUP;
            end
            else
            begin
                count_next     = COUNT_W'(count_reg + 1'b1);
                out_count_next = COUNT_W'(count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            launch_ctrl_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            launch_ctrl_reg <= launch_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_id_reg     <= out_id_next;
        launch_id_reg  <= launch_id_next;
        launch_idx_reg <= launch_idx_next;
    end

endmodule

### rtl/suidl_checker.sv
`include "sorted_unique_id_list_core_assert.svh"

module suidl_checker #(
    parameter int CAPACITY = 256,
    parameter int ID_WIDTH = 12
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((ID_WIDTH + suidl_pkg::INDEX_W + 7) / 8) * 8 - 1:0] s_tdata,
    input logic [suidl_pkg::KIND_W-1:0]           s_tuser,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((suidl_pkg::STATUS_W + $clog2(CAPACITY + 1) + ID_WIDTH + 7) / 8) * 8 - 1:0]
                                                  m_tdata
);
    import suidl_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic [STATUS_W-1:0] rsp_status;
    logic [COUNT_W-1:0]  rsp_count;
    logic [ID_WIDTH-1:0] rsp_id;
    logic                req_clear;

    assign rsp_status = m_tdata[STATUS_W-1:0];
    assign rsp_count  = m_tdata[STATUS_W +: COUNT_W];
    assign rsp_id     = m_tdata[STATUS_W + COUNT_W +: ID_WIDTH];
    assign req_clear  = s_tvalid && s_tready && (s_tuser == KIND_CLEAR);

    // A pending response is held until it is taken.
    `SUIDL_ASSERT_NEXT(a_rsp_held, m_tvalid && !m_tready, m_tvalid, "response dropped while stalled")
    // The count never exceeds the capacity.
    `SUIDL_ASSERT(a_count_bound, m_tvalid, rsp_count <= COUNT_W'(CAPACITY), "count above capacity")
    // Only a successful read returns a nonzero id.
    `SUIDL_ASSERT(a_id_zero, m_tvalid && (rsp_status != ST_DONE), rsp_id == '0, "id on failed request")
    // A clear is answered in the next cycle with an empty list.
    `SUIDL_ASSERT_NEXT(a_clear_rsp, req_clear, m_tvalid && (rsp_count == '0), "clear not answered")

endmodule

bind sorted_unique_id_list_core suidl_checker #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
) u_suidl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
